// ===== rtl/c39bl_pkg.sv =====
// ----------------------------------------------------------------------------
// c39bl_pkg
// Shared types, constants and the character lookup for the Code 39 bar
// layout engine.
// ----------------------------------------------------------------------------
package c39bl_pkg;

   // Item opcodes
   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_CHAR   = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE   = 2'd3
   } c39_op_type;

   // Register indexes on the csr port
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NARROW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 2'd2;

   // Register reset values
   localparam logic [15:0] NARROW_RESET  = 16'd2048;
   localparam logic [15:0] WIDE_RESET    = 16'd5120;
   localparam logic [31:0] START_X_RESET = 32'd0;

   // Saturation limit for x
   localparam logic signed [31:0] X_MAX = 32'sh7FFF_FFFF;

   // Element count and last bar index of one symbol
   localparam int unsigned PAT_W    = 9;
   localparam logic [2:0]  LAST_BAR = 3'd4;

   // Queue between front and back
   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // Nine-element patterns, first element in the top bit, 1 = wide
   localparam logic [PAT_W-1:0] PAT_STAR = 9'h094;

   localparam logic [PAT_W-1:0] DIGIT_PAT [10] = '{
      9'h034, 9'h121, 9'h061, 9'h160, 9'h031,
      9'h130, 9'h070, 9'h025, 9'h124, 9'h064
   };

   localparam logic [PAT_W-1:0] ALPHA_PAT [26] = '{
      9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C,
      9'h04C, 9'h01C, 9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052,
      9'h007, 9'h106, 9'h046, 9'h016, 9'h181, 9'h0C1, 9'h1C0, 9'h091,
      9'h190, 9'h0D0
   };

   // One queued symbol
   typedef struct packed {
      logic             is_begin;
      logic [PAT_W-1:0] pattern;
   } c39_entry_type;

   // Map a character to its pattern: fold lower case, unknown codes give '*'
   function automatic logic [PAT_W-1:0] pattern_of(input logic [7:0] c);
      logic [7:0]       cu;
      logic [7:0]       off;
      logic [PAT_W-1:0] pat;
      cu = c;
      if ((c >= 8'h61) && (c <= 8'h7A)) begin
         cu = c - 8'd32;
      end
      pat = PAT_STAR;
      if ((cu >= 8'h30) && (cu <= 8'h39)) begin
         off = cu - 8'h30;
         pat = DIGIT_PAT[off[3:0]];
      end else if ((cu >= 8'h41) && (cu <= 8'h5A)) begin
         off = cu - 8'h41;
         pat = ALPHA_PAT[off[4:0]];
      end else begin
         off = 8'd0;
         case (cu)
            8'h2D:   pat = 9'h085;   // '-'
            8'h2E:   pat = 9'h184;   // '.'
            8'h20:   pat = 9'h0C4;   // space
            8'h2B:   pat = 9'h08A;   // '+'
            8'h25:   pat = 9'h02A;   // '%'
            8'h24:   pat = 9'h0A8;   // '$'
            8'h2F:   pat = 9'h0A2;   // '/'
            default: pat = PAT_STAR;
         endcase
      end
      return pat;
   endfunction

endpackage

// ===== rtl/c39bl_front.sv =====
// ----------------------------------------------------------------------------
// c39bl_front
// Accepts items, drops the unused opcode and turns each symbol into its
// nine-element pattern for the queue.
// ----------------------------------------------------------------------------
module c39bl_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [7:0]               req_ch,
   input  logic                     q_full,
   output logic                     q_push,
   output c39bl_pkg::c39_entry_type q_entry
);
   import c39bl_pkg::*;

   c39_op_type op;

   assign op = c39_op_type'(req_op);

   // Hold the requester while the queue is full
   assign req_stall = q_full;

   // Push symbols only; the unused opcode is taken and dropped
   assign q_push = req_valid && !q_full && (op != OP_NONE);

   // Classify the item
   always_comb begin
      q_entry.is_begin = (op == OP_BEGIN);
      unique case (op)
         OP_CHAR: q_entry.pattern = pattern_of(req_ch);
         default: q_entry.pattern = PAT_STAR;
      endcase
   end

endmodule

// ===== rtl/c39bl_queue.sv =====
// ----------------------------------------------------------------------------
// c39bl_queue
// Short FIFO of classified symbols between the front and the back.
// ----------------------------------------------------------------------------
module c39bl_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  c39bl_pkg::c39_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output c39bl_pkg::c39_entry_type head_entry
);
   import c39bl_pkg::*;

   c39_entry_type       entries_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count exceeds depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

// ===== rtl/c39bl_back.sv =====
// ----------------------------------------------------------------------------
// c39bl_back
// Lays out the head symbol one bar per cycle unless the result is stalled,
// keeps the running x and the configuration registers, and drives the
// registered result.
module c39bl_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata,
   input  logic                     head_valid,
   input  c39bl_pkg::c39_entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_bar_x,
   output logic [15:0]              rsp_bar_width,
   output logic                     rsp_last_bar
);
   import c39bl_pkg::*;

   logic [15:0]        narrow_ff;
   logic [15:0]        wide_ff;
   logic signed [31:0] start_x_ff;
   logic signed [31:0] x_ff, x_in;
   logic [2:0]         idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic signed [31:0] bar_x_ff;
   logic [15:0]        bar_w_ff;
   logic               last_ff;

   logic               adv;
   logic               last_now;
   logic signed [31:0] x_base;
   logic               bar_wide, space_wide;
   logic [15:0]        bar_w, space_w;
   logic [16:0]        step;
   logic [32:0]        sum;
   logic signed [31:0] x_next;

   // Configuration writes, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         narrow_ff  <= NARROW_RESET;
         wide_ff    <= WIDE_RESET;
         start_x_ff <= START_X_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NARROW:  narrow_ff  <= csr_wdata[15:0];
            CSR_WIDE:    wide_ff    <= csr_wdata[15:0];
            CSR_START_X: start_x_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Step when a symbol waits and the result register is free
   assign adv      = head_valid && (!valid_ff || !rsp_stall);
   assign last_now = (idx_ff == LAST_BAR);
   assign pop      = adv && last_now;

   // Begin reloads x on its first bar
   assign x_base = ((idx_ff == '0) && head_entry.is_begin) ? start_x_ff : x_ff;

   // Pick this bar and the space after it; the last bar is followed by a narrow gap
   always_comb begin
      unique case (idx_ff)
         3'd0:    begin bar_wide = head_entry.pattern[8]; space_wide = head_entry.pattern[7]; end
         3'd1:    begin bar_wide = head_entry.pattern[6]; space_wide = head_entry.pattern[5]; end
         3'd2:    begin bar_wide = head_entry.pattern[4]; space_wide = head_entry.pattern[3]; end
         3'd3:    begin bar_wide = head_entry.pattern[2]; space_wide = head_entry.pattern[1]; end
         3'd4:    begin bar_wide = head_entry.pattern[0]; space_wide = 1'b0;                 end
         default: begin bar_wide = 1'b0;                  space_wide = 1'b0;                 end
      endcase
   end

   assign bar_w   = bar_wide   ? wide_ff : narrow_ff;
   assign space_w = space_wide ? wide_ff : narrow_ff;
   assign step    = {1'b0, bar_w} + {1'b0, space_w};

   // Advance x and clamp at the top; widths never make it fall
   assign sum    = {x_base[31], x_base} + {16'd0, step};
   assign x_next = (sum[32:31] == 2'b01) ? X_MAX : sum[31:0];

   always_comb begin
      x_in     = x_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      if (adv) begin
         x_in     = x_next;
         idx_in   = last_now ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         x_ff     <= x_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Load the result register on each step
   always_ff @(posedge clock) begin
      if (adv) begin
         bar_x_ff <= x_base;
         bar_w_ff <= bar_w;
         last_ff  <= last_now;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_bar_x     = bar_x_ff;
   assign rsp_bar_width = bar_w_ff;
   assign rsp_last_bar  = last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_BAR)
      else $error("bar counter out of range");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      adv |=> (rsp_last_bar == ($past(idx_ff) == LAST_BAR)))
      else $error("last bar flag does not follow the bar counter");

   a_x_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(x_ff))
      else $error("x moved without a bar step");

endmodule

// ===== rtl/code39_bar_layout.sv =====
// ----------------------------------------------------------------------------
// code39_bar_layout
// Code 39 bar layout engine: begin, character and finish items in, five bar
// rectangles (left edge and width) out per symbol.
// ----------------------------------------------------------------------------
// Each begin, character or finish item yields five results, one bar per
// cycle while the receiver does not stall; the bar counter in the back end
// walks the bars. The first bar of an item passes through the queue and the
// result register before it is presented, and the front keeps taking items
// into a two-entry queue while the back lays out earlier ones. An item with
// opcode 3 is taken and yields nothing. Lower case folds to upper case and
// codes with no pattern use the '*' pattern. x is signed Q24.8 and clamps at
// its maximum; widths are unsigned Q8.8. Write registers only while the
// block is idle.
// ----------------------------------------------------------------------------
module code39_bar_layout (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [7:0]         req_ch,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_bar_x,
   output logic [15:0]        rsp_bar_width,
   output logic               rsp_last_bar,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import c39bl_pkg::*;

   logic          q_full;
   logic          q_push;
   c39_entry_type q_entry;
   logic          q_pop;
   logic          q_head_valid;
   c39_entry_type q_head;

   // Classify incoming items
   c39bl_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   // Decouple front and back
   c39bl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   // Lay out bars
   c39bl_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .head_valid    (q_head_valid),
      .head_entry    (q_head),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bar_x     (rsp_bar_x),
      .rsp_bar_width (rsp_bar_width),
      .rsp_last_bar  (rsp_last_bar)
   );

endmodule

// ===== tb/sv/tb_code39_bar_layout.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_code39_bar_layout
// Self-checking bench for the Code 39 bar layout engine. A local predictor
// keeps its own copy of the widths, start position and running x, lays out
// the five bars of every accepted symbol, and a checker compares each bar
// transfer field by field against the oldest prediction. Directed symbols,
// register extremes, x clamping, random symbol streams under several idle
// and stall mixes, and a long receiver hold-off are run in turn.
// ----------------------------------------------------------------------------
module tb_code39_bar_layout;
   import c39bl_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic signed [31:0] X_CLAMP = 32'sh7FFF_FFFF;

   // Code 39 element patterns, first element in bit 8, 1 = wide
   localparam logic [8:0] STAR_BARS = 9'h094;
   localparam logic [8:0] DIGIT_BARS [10] = '{
      9'h034, 9'h121, 9'h061, 9'h160, 9'h031,
      9'h130, 9'h070, 9'h025, 9'h124, 9'h064
   };
   localparam logic [8:0] LETTER_BARS [26] = '{
      9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C,
      9'h04C, 9'h01C, 9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052,
      9'h007, 9'h106, 9'h046, 9'h016, 9'h181, 9'h0C1, 9'h1C0, 9'h091,
      9'h190, 9'h0D0
   };

   typedef struct packed {
      logic signed [31:0] x;
      logic [15:0]        width;
      logic               is_last;
   } bar_rect_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op = OP_BEGIN;
   logic [7:0]         req_ch = 8'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_bar_x;
   logic [15:0]        rsp_bar_width;
   logic               rsp_last_bar;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_NARROW;
   logic [31:0]        csr_wdata = 32'd0;

   // Shadow registers and running x of the predictor
   logic [15:0]        narrow_w  = NARROW_RESET;
   logic [15:0]        wide_w    = WIDE_RESET;
   logic signed [31:0] start_pos = START_X_RESET;
   logic signed [31:0] x_pos     = 32'sd0;

   bar_rect_type expected_bars [$];
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_request  = 0;
   int unsigned hold_left     = 0;

   string code39_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-. $/+%abcxyz";

   code39_bar_layout dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_ch        (req_ch),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bar_x     (rsp_bar_x),
      .rsp_bar_width (rsp_bar_width),
      .rsp_last_bar  (rsp_last_bar),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Compare each bar transfer with the oldest predicted bar
   always @(posedge clock) begin
      bar_rect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bars.size() == 0) begin
            $error("unexpected bar: x %0d width %0d last %0b",
                   rsp_bar_x, rsp_bar_width, rsp_last_bar);
            error_count++;
         end else begin
            want = expected_bars.pop_front();
            if (rsp_bar_x !== want.x) begin
               $error("bar_x: expected %0d, got %0d", want.x, rsp_bar_x);
               error_count++;
            end
            if (rsp_bar_width !== want.width) begin
               $error("bar_width: expected %0d, got %0d", want.width, rsp_bar_width);
               error_count++;
            end
            if (rsp_last_bar !== want.is_last) begin
               $error("last_bar: expected %0b, got %0b", want.is_last, rsp_last_bar);
               error_count++;
            end
         end
      end
   end

   // Element pattern of a character: fold lower case, unknown codes give '*'
   function automatic logic [8:0] code39_pattern(input logic [7:0] c);
      logic [7:0] u;
      logic [7:0] off;
      u = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
      if ((u >= "0") && (u <= "9")) begin
         off = u - 8'h30;
         return DIGIT_BARS[off[3:0]];
      end
      if ((u >= "A") && (u <= "Z")) begin
         off = u - 8'h41;
         return LETTER_BARS[off[4:0]];
      end
      case (u)
         "-":     return 9'h085;
         ".":     return 9'h184;
         " ":     return 9'h0C4;
         "+":     return 9'h08A;
         "%":     return 9'h02A;
         "$":     return 9'h0A8;
         "/":     return 9'h0A2;
         default: return STAR_BARS;
      endcase
   endfunction

   // Add a width to x, clamping at the top of the range
   function automatic logic signed [31:0] step_x(input logic signed [31:0] x,
                                                 input logic [15:0] w);
      longint s;
      s = longint'(x) + longint'({16'd0, w});
      return (s > longint'(X_CLAMP)) ? X_CLAMP : s[31:0];
   endfunction

   // Lay out the five bars of one symbol and advance x past it
   task automatic lay_out_symbol(input c39_op_type op, input logic [7:0] ch);
      logic [8:0]   pat;
      logic [15:0]  w;
      bar_rect_type bar;
      if (op == OP_NONE) begin
         return;
      end
      if (op == OP_BEGIN) begin
         x_pos = start_pos;
      end
      pat = (op == OP_CHAR) ? code39_pattern(ch) : STAR_BARS;
      for (int i = 0; i < 9; i++) begin
         w = pat[8 - i] ? wide_w : narrow_w;
         if ((i % 2) == 0) begin
            bar.x = x_pos;
            bar.width = w;
            bar.is_last = (i == 8);
            expected_bars.push_back(bar);
         end
         x_pos = step_x(x_pos, w);
      end
      x_pos = step_x(x_pos, narrow_w);
   endtask

   // Offer one item, wait for its transfer, then predict its bars
   task automatic send_item(input c39_op_type op, input logic [7:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_ch    <= ch;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      lay_out_symbol(op, ch);
   endtask

   // Drop valid, let every predicted bar arrive, then allow the pipe to empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bars.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register and mirror it in the shadow copy
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_NARROW:  narrow_w = data[15:0];
         CSR_WIDE:    wide_w = data[15:0];
         CSR_START_X: start_pos = data;
         default:     ;
      endcase
   endtask

   task automatic write_widths(input logic [15:0] narrow, input logic [15:0] wide,
                               input logic [31:0] origin);
      write_reg(CSR_NARROW, {16'd0, narrow});
      write_reg(CSR_WIDE, {16'd0, wide});
      write_reg(CSR_START_X, origin);
   endtask

   // Mostly legal Code 39 characters, sometimes any code at all
   function automatic logic [7:0] random_char();
      if ($urandom_range(9) < 7) begin
         return code39_chars[$urandom_range(code39_chars.len() - 1)];
      end
      return 8'($urandom_range(255));
   endfunction

   // A whole symbol: begin, a few characters, finish
   task automatic send_symbol(input int unsigned n_chars);
      send_item(OP_BEGIN, 8'($urandom_range(255)));
      for (int i = 0; i < n_chars; i++) begin
         send_item(OP_CHAR, random_char());
      end
      send_item(OP_FINISH, 8'($urandom_range(255)));
   endtask

   // Reset widths: every character class and the unused opcode
   task automatic test_character_set();
      logic [7:0] chars [18] = '{
         8'h00, "0", "9", "A", "Z", "a", "z", "-", ".", " ",
         "+", "%", "$", "/", "*", 8'h7F, 8'hFF, "m"
      };
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(OP_BEGIN, 8'hFF);
      foreach (chars[i]) begin
         send_item(OP_CHAR, chars[i]);
      end
      send_item(OP_NONE, 8'hFF);
      send_item(OP_FINISH, 8'h55);
      send_item(OP_NONE, 8'h00);
      send_item(OP_CHAR, "Q");
      settle();
   endtask

   // Register extremes, including a write to the unused index
   task automatic test_register_extremes();
      write_widths(16'd0, 16'd0, 32'd0);
      send_item(OP_BEGIN, 8'd0);
      send_item(OP_CHAR, "W");
      send_item(OP_FINISH, 8'd0);
      settle();
      write_widths(16'hFFFF, 16'hFFFF, 32'h8000_0000);
      send_symbol(2);
      settle();
      write_widths(16'd0, 16'hFFFF, 32'hFFFF_FF00);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      send_symbol(3);
      settle();
   endtask

   // x runs into the top of its range and stays clamped
   task automatic test_x_clamp();
      write_widths(16'h0100, 16'h0300, 32'h7FFF_F000);
      send_symbol(6);
      settle();
      write_reg(CSR_START_X, X_CLAMP);
      send_symbol(1);
      settle();
   endtask

   // Random symbol streams with some noise, under one idle and stall mix
   task automatic test_random_traffic(input int unsigned idle_pct,
                                      input int unsigned stall_pct,
                                      input int unsigned n_items);
      int unsigned sent;
      int unsigned n_chars;
      c39_op_type  op;
      if ($urandom_range(3) == 0) begin
         write_widths(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      $urandom());
      end else begin
         write_widths(16'($urandom_range(1, 16'h0400)),
                      16'($urandom_range(1, 16'h0C00)), $urandom());
      end
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            op = c39_op_type'($urandom_range(3));
            send_item(op, 8'($urandom_range(255)));
            if (op != OP_NONE) begin
               sent++;
            end
         end else begin
            n_chars = $urandom_range(1, 8);
            send_symbol(n_chars);
            sent += n_chars + 2;
         end
      end
      settle();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // Hold the receiver off while items keep coming, so the input backs up
   task automatic test_backpressure();
      write_widths(16'($urandom_range(1, 16'h0400)), 16'($urandom_range(1, 16'h0C00)),
                   $urandom());
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request = 300;
      send_symbol(12);
      settle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_character_set();
      test_register_extremes();
      test_x_clamp();
      test_random_traffic(0, 0, 40);
      test_random_traffic(45, 0, 40);
      test_random_traffic(0, 45, 40);
      test_random_traffic(28, 28, 40);
      test_backpressure();

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
